>>> hdl/sgm_pkg.sv
`default_nettype none

package sgm_pkg;

   localparam int SAMPLE_W       = 8;
   localparam int LINE_WIDTH_W   = 12;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 1;

   // one line store entry: {upper, middle}
   localparam int PAIR_W = 2 * SAMPLE_W;

   // Sobel sums and gradients
   localparam int SUM_W  = SAMPLE_W + 2;
   localparam int GRAD_W = SUM_W + 1;
   localparam int ABS_W  = SUM_W;
   localparam int PROD_W = 2 * ABS_W;
   localparam int SQ_W   = PROD_W + 1;

   // root unit
   localparam int ROOT_W = 8;
   localparam int RAD_W  = 2 * ROOT_W;

   localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RESET   = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam int                        DIM_MIN            = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] magnitude;
      logic                line_end;
      logic                frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [ROOT_W-1:0] root;
   } root_status_type;

endpackage

`default_nettype wire

>>> hdl/sgm_line_mem.sv
`default_nettype none

module sgm_line_mem
   import sgm_pkg::*;
#(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [PAIR_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output      logic [PAIR_W-1:0] rd_data
);

   logic [PAIR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/sgm_isqrt.sv
`default_nettype none

module sgm_isqrt
   import sgm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [SQ_W-1:0] operand,
   output      root_status_type status
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ROOT_W-1:0] bit_ff, bit_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [RAD_W-1:0]  value_ff, value_in;
   logic [ROOT_W-1:0] trial;
   logic [RAD_W-1:0]  trial_sq;

   // one result bit per cycle, MSB first
   always_comb begin
      trial    = root_ff | bit_ff;
      trial_sq = RAD_W'(trial) * RAD_W'(trial);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      bit_in   = bit_ff;
      root_in  = root_ff;
      value_in = value_ff;
      if (start) begin
         if (|operand[SQ_W-1:RAD_W]) begin
            // radicand of 2^16 or more saturates
            root_in = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            value_in = operand[RAD_W-1:0];
            root_in  = '0;
            bit_in   = {1'b1, {(ROOT_W-1){1'b0}}};
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial_sq <= value_ff) begin
            root_in = trial;
         end
         bit_in = bit_ff >> 1;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff   <= bit_in;
      root_ff  <= root_in;
      value_ff <= value_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.root = root_ff;

endmodule

`default_nettype wire

>>> hdl/sobel_gradient_magnitude_3x3_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_payload_type {sample, frame_start}
// rsp_      out        rsp_valid/rsp_stall  rsp_payload_type {magnitude, line_end, frame_end}
// csr_      in         csr_write            csr_index, csr_wdata (no read-back)
//
// One request at a time. A border pixel passes through accept and the line store
// read-modify-write only. An interior pixel then squares gx and gy and waits on
// the 8-step bit-serial root unit, which skips its steps when the sum of squares saturates.
// Reset (synchronous, active high) clears position, window and control; the
// line store holds no reset value and is filled by the stream itself.
// The result register decouples the sides: a new request is taken while a
// result waits on rsp_stall; only a finished root waits for the register.

module sobel_gradient_magnitude_3x3_top
   import sgm_pkg::*;
#(
   parameter int MAX_LINE_WIDTH   = 2048,
   parameter int MAX_FRAME_HEIGHT = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire req_payload_type        req_payload,
   // result channel
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      rsp_payload_type        rsp_payload,
   // configuration writes
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // column / row index widths and compare widths
   localparam int AW  = $clog2(MAX_LINE_WIDTH);
   localparam int RW  = $clog2(MAX_FRAME_HEIGHT);
   localparam int WCW = $clog2(MAX_LINE_WIDTH + 1);
   localparam int HCW = $clog2(MAX_FRAME_HEIGHT + 1);
   localparam int WEW = (LINE_WIDTH_W > WCW) ? LINE_WIDTH_W : WCW;
   localparam int HEW = (FRAME_HEIGHT_W > HCW) ? FRAME_HEIGHT_W : HCW;

   localparam logic [WEW-1:0] W_MAX = WEW'(MAX_LINE_WIDTH);
   localparam logic [WEW-1:0] W_MIN = WEW'(DIM_MIN);
   localparam logic [HEW-1:0] H_MAX = HEW'(MAX_FRAME_HEIGHT);
   localparam logic [HEW-1:0] H_MIN = HEW'(DIM_MIN);

   typedef enum logic [2:0] {
      ST_IDLE,  // take a request, issue line store read
      ST_READ,  // read data back: write store, shift window, form gx/gy
      ST_SQX,   // gx^2
      ST_SQY,   // + gy^2, kick root unit
      ST_ROOT,  // wait for root
      ST_HOLD   // wait for result register
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [LINE_WIDTH_W-1:0]   line_width_ff, line_width_in;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff, frame_height_in;

   // raster position
   logic [AW-1:0] col_pos_ff, col_pos_in;
   logic [RW-1:0] row_pos_ff, row_pos_in;

   // current request
   logic [AW-1:0]       col_ff, col_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                last_col_ff, last_col_in;
   logic                last_row_ff, last_row_in;
   logic                interior_ff, interior_in;

   // window: [0..2] two columns back (top, mid, bottom), [3..5] one back
   logic [SAMPLE_W-1:0] win_ff [6];
   logic [SAMPLE_W-1:0] win_in [6];

   logic signed [GRAD_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic                     start_ff, start_in;
   logic [ROOT_W-1:0]        mag_ff, mag_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // combinational
   logic [WEW-1:0]      lw_ext, w_eff, w_last;
   logic [HEW-1:0]      fh_ext, h_eff, h_last;
   logic [AW-1:0]       col_raw, col_cur;
   logic [RW-1:0]       row_raw, row_cur;
   logic                last_col_cur, last_row_cur;
   logic                req_accept, out_free;
   logic [SAMPLE_W-1:0] top_px, mid_px;
   logic [SUM_W-1:0]    sum_r, sum_l, sum_b, sum_t;
   logic [GRAD_W-1:0]   gx_mag, gy_mag;
   logic [ABS_W-1:0]    abs_sel;
   logic [PROD_W-1:0]   prod;
   logic [PAIR_W-1:0]   rd_data;
   root_status_type     root_status;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // effective dimensions, clamped to 3..MAX
   always_comb begin
      lw_ext = WEW'(line_width_ff);
      fh_ext = HEW'(frame_height_ff);
      w_eff  = (lw_ext < W_MIN) ? W_MIN : ((lw_ext > W_MAX) ? W_MAX : lw_ext);
      h_eff  = (fh_ext < H_MIN) ? H_MIN : ((fh_ext > H_MAX) ? H_MAX : fh_ext);
      w_last = w_eff - WEW'(1);
      h_last = h_eff - HEW'(1);
   end

   // position of the incoming sample; out-of-range after a resize sticks at the edge
   always_comb begin
      col_raw      = req_payload.frame_start ? '0 : col_pos_ff;
      row_raw      = req_payload.frame_start ? '0 : row_pos_ff;
      col_cur      = (WEW'(col_raw) >= w_eff) ? w_last[AW-1:0] : col_raw;
      row_cur      = (HEW'(row_raw) >= h_eff) ? h_last[RW-1:0] : row_raw;
      last_col_cur = (WEW'(col_cur) == w_last);
      last_row_cur = (HEW'(row_cur) == h_last);
   end

   assign top_px = rd_data[PAIR_W-1:SAMPLE_W];
   assign mid_px = rd_data[SAMPLE_W-1:0];

   // Sobel column/row sums
   always_comb begin
      sum_r = SUM_W'(top_px) + {1'b0, mid_px, 1'b0} + SUM_W'(sample_ff);
      sum_l = SUM_W'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + SUM_W'(win_ff[2]);
      sum_b = SUM_W'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + SUM_W'(sample_ff);
      sum_t = SUM_W'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + SUM_W'(top_px);
   end

   // one shared squarer for gx then gy
   always_comb begin
      gx_mag  = gx_ff[GRAD_W-1] ? GRAD_W'(-gx_ff) : GRAD_W'(gx_ff);
      gy_mag  = gy_ff[GRAD_W-1] ? GRAD_W'(-gy_ff) : GRAD_W'(gy_ff);
      abs_sel = (state_ff == ST_SQX) ? gx_mag[ABS_W-1:0] : gy_mag[ABS_W-1:0];
      prod    = PROD_W'(abs_sel) * PROD_W'(abs_sel);
   end

   always_comb begin
      state_in        = state_ff;
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      col_pos_in      = col_pos_ff;
      row_pos_in      = row_pos_ff;
      col_in          = col_ff;
      sample_in       = sample_ff;
      last_col_in     = last_col_ff;
      last_row_in     = last_row_ff;
      interior_in     = interior_ff;
      win_in          = win_ff;
      gx_in           = gx_ff;
      gy_in           = gy_ff;
      sq_in           = sq_ff;
      start_in        = 1'b0;
      mag_in          = mag_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_LINE_WIDTH:   line_width_in   = csr_wdata[LINE_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               col_in      = col_cur;
               sample_in   = req_payload.sample;
               last_col_in = last_col_cur;
               last_row_in = last_row_cur;
               interior_in = (col_cur >= AW'(2)) && (row_cur >= RW'(2));
               if (last_col_cur) begin
                  col_pos_in = '0;
                  row_pos_in = last_row_cur ? '0 : row_cur + RW'(1);
               end else begin
                  col_pos_in = col_cur + AW'(1);
                  row_pos_in = row_cur;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            gx_in     = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
            gy_in     = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
            win_in[0] = win_ff[3];
            win_in[1] = win_ff[4];
            win_in[2] = win_ff[5];
            win_in[3] = top_px;
            win_in[4] = mid_px;
            win_in[5] = sample_ff;
            state_in  = interior_ff ? ST_SQX : ST_IDLE;
         end
         ST_SQX: begin
            sq_in    = SQ_W'(prod);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sq_in    = sq_ff + SQ_W'(prod);
            start_in = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_status.done) begin
               mag_in   = root_status.root;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_payload_in.magnitude = mag_ff;
               rsp_payload_in.line_end  = last_col_ff;
               rsp_payload_in.frame_end = last_col_ff && last_row_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_pos_ff      <= '0;
         row_pos_ff      <= '0;
         win_ff          <= '{default: '0};
         start_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
         col_pos_ff      <= col_pos_in;
         row_pos_ff      <= row_pos_in;
         win_ff          <= win_in;
         start_ff        <= start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      col_ff         <= col_in;
      sample_ff      <= sample_in;
      last_col_ff    <= last_col_in;
      last_row_ff    <= last_row_in;
      interior_ff    <= interior_in;
      gx_ff          <= gx_in;
      gy_ff          <= gy_in;
      sq_ff          <= sq_in;
      mag_ff         <= mag_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // {upper, middle} line store: read at accept, written back in the following cycle
   sgm_line_mem #(
      .DEPTH (MAX_LINE_WIDTH),
      .AW    (AW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (col_ff),
      .wr_data ({mid_px, sample_ff}),
      .rd_en   (req_accept),
      .rd_addr (col_cur),
      .rd_data (rd_data)
   );

   sgm_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .operand (sq_ff),
      .status  (root_status)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // frame end is always also a line end
   a_frame_end_on_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_payload.frame_end || rsp_payload.line_end))
      else $error("frame_end without line_end");

   // a new request never lands while the root unit is still iterating
   a_accept_root_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !root_status.busy)
      else $error("request accepted while root unit busy");

   // a root completes only while the sequencer is waiting for it
   a_root_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      root_status.done |-> (state_ff == ST_ROOT))
      else $error("root done outside wait state");

   // a result is loaded only from the hold state
   a_result_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_HOLD))
      else $error("result loaded outside hold state");

endmodule

`default_nettype wire

>>> verif/sgm_scoreboard_pkg.sv
package sgm_scoreboard_pkg;

   import sgm_pkg::*;

   localparam int MAX_COLS = 2048;
   localparam int MAX_ROWS = 4096;

   class magnitude_scoreboard;

      bit [LINE_WIDTH_W-1:0]   width_reg;
      bit [FRAME_HEIGHT_W-1:0] height_reg;
      bit [SAMPLE_W-1:0]       upper_line  [MAX_COLS];
      bit [SAMPLE_W-1:0]       middle_line [MAX_COLS];
      // [0..2] two columns back, [3..5] one column back; top, middle, bottom
      bit [SAMPLE_W-1:0]       window_cols [6];
      int unsigned             col_pos;
      int unsigned             row_pos;
      rsp_payload_type         expected_pixels [$];
      int unsigned             mismatches;

      function new();
         width_reg  = LINE_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         col_pos    = 0;
         row_pos    = 0;
         mismatches = 0;
      endfunction

      function int unsigned clamp_dim(int unsigned raw, int unsigned hi);
         if (raw < DIM_MIN) return DIM_MIN;
         if (raw > hi) return hi;
         return raw;
      endfunction

      function int unsigned eff_width();
         return clamp_dim(width_reg, MAX_COLS);
      endfunction

      function int unsigned eff_height();
         return clamp_dim(height_reg, MAX_ROWS);
      endfunction

      function int unsigned outstanding();
         return expected_pixels.size();
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_LINE_WIDTH:   width_reg  = value[LINE_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: height_reg = value[FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
      endfunction

      // floor of the square root, pinned at 255 once the root would pass it
      function int unsigned floor_root(int unsigned v);
         int unsigned r;
         r = 0;
         if (v >= 65536) return 255;
         while ((r + 1) * (r + 1) <= v) r++;
         return r;
      endfunction

      function void note_sample(req_payload_type item);
         int unsigned       w, h, c, r;
         bit [SAMPLE_W-1:0] top_px, mid_px;
         int                l0, l1, l2, c0, c2, r0, r1, r2, gx, gy;
         bit                end_col, end_row;
         rsp_payload_type   pixel;
         w = eff_width();
         h = eff_height();
         if (item.frame_start) begin
            col_pos = 0;
            row_pos = 0;
         end
         c = (col_pos >= w) ? w - 1 : col_pos;
         r = (row_pos >= h) ? h - 1 : row_pos;
         top_px = upper_line[c];
         mid_px = middle_line[c];
         upper_line[c]  = mid_px;
         middle_line[c] = item.sample;
         end_col = (c == w - 1);
         end_row = (r == h - 1);
         if (r >= 2 && c >= 2) begin
            l0 = window_cols[0];
            l1 = window_cols[1];
            l2 = window_cols[2];
            c0 = window_cols[3];
            c2 = window_cols[5];
            r0 = top_px;
            r1 = mid_px;
            r2 = item.sample;
            gx = (r0 + 2 * r1 + r2) - (l0 + 2 * l1 + l2);
            gy = (l2 + 2 * c2 + r2) - (l0 + 2 * c0 + r0);
            pixel.magnitude = SAMPLE_W'(floor_root(gx * gx + gy * gy));
            pixel.line_end  = end_col;
            pixel.frame_end = end_col && end_row;
            expected_pixels.push_back(pixel);
         end
         window_cols[0] = window_cols[3];
         window_cols[1] = window_cols[4];
         window_cols[2] = window_cols[5];
         window_cols[3] = top_px;
         window_cols[4] = mid_px;
         window_cols[5] = item.sample;
         if (end_col) begin
            col_pos = 0;
            row_pos = end_row ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
            row_pos = r;
         end
      endfunction

      function void check_pixel(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with no pixel pending: mag %0d line_end %0b frame_end %0b",
                        got.magnitude, got.line_end, got.frame_end);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.magnitude !== want.magnitude || got.line_end !== want.line_end ||
             got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel mismatch: expected mag %0d le %0b fe %0b, got mag %0d le %0b fe %0b",
                        want.magnitude, want.line_end, want.frame_end,
                        got.magnitude, got.line_end, got.frame_end);
         end
      endfunction

   endclass

endpackage

>>> verif/tb_sobel_gradient_magnitude_3x3_top.sv
module tb_sobel_gradient_magnitude_3x3_top;

   import sgm_pkg::*;
   import sgm_scoreboard_pkg::*;

   localparam int RANDOM_ITEMS  = 1400;
   // head of each oversized frame that is actually streamed
   localparam int EXTREME_ITEMS = 300;
   // settle time after the last result for the block to go quiet
   localparam int DRAIN_CYCLES  = 24;
   // long receiver hold-off, enough to back the block up into the request side
   localparam int HOLD_CYCLES   = 400;
   // cycles with no handshake on either side before the run is called hung
   localparam int QUIET_LIMIT   = 3000;

   // how a frame's pixel values are generated
   typedef enum {PIX_NOISE, PIX_EXTREME, PIX_RAMP, PIX_FLAT} pixel_style_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_write   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   magnitude_scoreboard board = new();

   bit          gaps_on      = 1'b1;  // random idling on both sides
   bit          hold_armed   = 1'b0;  // asks the receiver for its one long hold-off
   int unsigned sent_items   = 0;
   int unsigned quiet_cycles = 0;

   sobel_gradient_magnitude_3x3_top #(
      .MAX_LINE_WIDTH   (MAX_COLS),
      .MAX_FRAME_HEIGHT (MAX_ROWS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- helpers

   function automatic logic [SAMPLE_W-1:0] pick_pixel(pixel_style_type style,
                                                      logic [SAMPLE_W-1:0] prev);
      case (style)
         PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         // small steps keep the gradient well under saturation
         PIX_RAMP:    return prev + SAMPLE_W'($urandom_range(0, 6)) - 8'd3;
         PIX_FLAT:    return ($urandom_range(0, 15) == 0) ? SAMPLE_W'($urandom) : prev;
         default:     return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Offer one request and hold it until the block takes it. The stall seen
   // right after the edge is the value the block had at that edge.
   task automatic send_sample(input logic [SAMPLE_W-1:0] pix, input logic fs);
      req_payload_type item;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      item.sample      = pix;
      item.frame_start = fs;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      board.note_sample(item);
      sent_items++;
   endtask

   // Stream count pixels in raster order; frame_start only on the first one.
   task automatic send_frame(input bit fs_first, input int unsigned count);
      pixel_style_type     style;
      logic [SAMPLE_W-1:0] pix;
      style = pixel_style_type'($urandom_range(0, 3));
      pix   = SAMPLE_W'($urandom);
      for (int unsigned i = 0; i < count; i++) begin
         pix = pick_pixel(style, pix);
         send_sample(pix, fs_first && i == 0);
      end
   endtask

   // Let every pending pixel come back, then give a border pixel still in
   // flight (it has no result to wait on) time to retire.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Both dimension registers, back to back, only once the block is quiet.
   task automatic write_dims(input logic [CSR_DATA_W-1:0] width_raw,
                             input logic [CSR_DATA_W-1:0] height_raw);
      drain_block();
      csr_write <= 1'b1;
      csr_index <= CSR_LINE_WIDTH;
      csr_wdata <= width_raw;
      @(posedge clock);
      board.set_register(CSR_LINE_WIDTH, width_raw);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= height_raw;
      @(posedge clock);
      board.set_register(CSR_FRAME_HEIGHT, height_raw);
      csr_write <= 1'b0;
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      logic [SAMPLE_W-1:0]   edge_frame [9];
      logic [SAMPLE_W-1:0]   soft_frame [9];
      logic [CSR_DATA_W-1:0] width_raw, height_raw;
      int unsigned           random_base, full, cut, frames;
      bit                    restart;

      // hard vertical edge: gx = 1020, root saturates
      edge_frame = '{8'd0, 8'd0, 8'd255,
                     8'd0, 8'd0, 8'd255,
                     8'd0, 8'd0, 8'd255};
      // gentle top-to-bottom step: gy = 12, gx = 0, center is ignored
      soft_frame = '{8'd10, 8'd10,  8'd10,
                     8'd10, 8'd200, 8'd10,
                     8'd13, 8'd13,  8'd13};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed part
      // raw 0 and 1 both clamp up to the 3x3 minimum: one interior pixel
      write_dims(13'd0, 13'd1);
      for (int i = 0; i < 9; i++) send_sample(edge_frame[i], i == 0);
      // no frame_start: position must have wrapped to the origin by itself
      for (int i = 0; i < 9; i++) send_sample(soft_frame[i], 1'b0);
      // frame cut short, next one forces the origin with frame_start
      send_frame(1'b1, 4);
      write_dims(13'd4, 13'd5);
      // two full lines plus three pixels of the third: next column is 3
      send_frame(1'b1, 11);
      // width shrinks under the cursor: column 3 becomes the line end
      write_dims(13'd3, 13'd5);
      send_frame(1'b0, 1);
      // height shrinks under the cursor: row 3 becomes the last row
      write_dims(13'd3, 13'd3);
      send_frame(1'b0, 3);

      // --- extreme sizes, both clamped from above; only the head of each frame
      // 4095 -> 2048 wide, 0 -> 3 lines
      write_dims(13'h0FFF, 13'd0);
      send_frame(1'b1, EXTREME_ITEMS);
      // top bit of the width write is dropped (-> 1 -> 3); 8191 -> 4096 lines.
      // One result per line piles up behind the receiver's long hold-off here.
      write_dims(13'h1001, 13'h1FFF);
      hold_armed = 1'b1;
      send_frame(1'b1, EXTREME_ITEMS);

      // --- random part: small frames, mostly whole, some cut short
      random_base = sent_items;
      while (sent_items - random_base < RANDOM_ITEMS) begin
         case ($urandom_range(0, 15))
            0:       width_raw = CSR_DATA_W'($urandom_range(0, 2));
            1:       width_raw = CSR_DATA_W'($urandom_range(13, 40));
            default: width_raw = CSR_DATA_W'($urandom_range(3, 12));
         endcase
         width_raw[CSR_DATA_W-1] = 1'($urandom_range(0, 1));
         height_raw = CSR_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                              : $urandom_range(3, 8));
         write_dims(width_raw, height_raw);
         full    = board.eff_width() * board.eff_height();
         frames  = $urandom_range(1, 3);
         // a new size always opens on a frame_start; so does a frame after a cut
         restart = 1'b1;
         for (int f = 0; f < frames; f++) begin
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, full - 1) : full;
            send_frame(restart || $urandom_range(0, 1), cut);
            restart = (cut != full);
         end
         // last stretch runs at full rate on both sides
         if (sent_items - random_base >= RANDOM_ITEMS * 17 / 20) gaps_on = 1'b0;
      end

      gaps_on = 1'b0;
      drain_block();
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("sobel_gradient_magnitude_3x3_top verification clean");
      end else begin
         $display("sobel_gradient_magnitude_3x3_top verification failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // Random stall bursts, plus one long hold-off once it is armed; the
   // sender keeps offering so the block fills and stalls its request side.
   initial begin : result_pacing
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (gaps_on && !reset && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // every accepted result against the oldest pending pixel
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_pixel(rsp_payload);
   end

   // hang detection: no handshake on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("sobel_gradient_magnitude_3x3_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
